// ===== design/stff_pkg.sv =====
package stff_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_NULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SCN_IDLE,
        SCN_GET,
        SCN_SCAN,
        SCN_DONE
    } scan_state_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] item_value;
        logic [7:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  result_index;
        logic [31:0] result_value;
        logic [8:0]  stored_count;
    } out_item_t;

    // Control strobes from the scan sequencer to the slot memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_one;
        logic clr_all;
    } mem_ctl_t;

endpackage

// ===== design/slot_table_first_free_core.sv =====
// Slot table with first-free allocation. Each input beat carries one operation (add, remove,
// get, clear) and produces exactly one result beat. The tokens live in a single-port-read,
// single-port-write SRAM-style array of SLOTS entries with a registered read; per-entry
// valid flops make reset and clear take effect at once, with no clearing pass. Add and remove
// scan the array from slot 0 upward, one read per cycle with each entry compared in the cycle
// after its read. One item is processed at a time; a new beat is accepted while the previous
// result still waits in the output register.
module slot_table_first_free_core #(
    parameter int SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stff_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stff_pkg::out_item_t m_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    stff_pkg::mem_ctl_t  mem_ctl;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    logic [31:0]         wr_data;
    logic [31:0]         rd_value;
    logic                out_load;
    logic                out_free;
    stff_pkg::out_item_t out_item;

    logic                m_valid_reg, m_valid_next;
    stff_pkg::out_item_t m_data_reg;

    stff_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_value (rd_value)
    );

    stff_scan #(
        .SLOTS (SLOTS),
        .IW    (IW),
        .CW    (CW)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (s_data),
        .out_free (out_free),
        .out_load (out_load),
        .out_item (out_item),
        .mem_ctl  (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_value (rd_value)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/stff_mem.sv =====
module stff_mem #(
    parameter int SLOTS = 16,
    parameter int IW    = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  stff_pkg::mem_ctl_t ctl,
    input  logic [IW-1:0]     rd_addr,
    input  logic [IW-1:0]     wr_addr,
    input  logic [31:0]       wr_data,
    output logic [31:0]       rd_value
);

    logic [31:0]      mem [SLOTS];
    logic [31:0]      rd_data_reg;
    logic             rd_valid_reg;
    logic             rd_valid_next;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry without its valid bit reads as empty, so reset and clear
    // never have to touch the array itself.
    always_comb begin
        valid_next = valid_reg;
        if (ctl.clr_all) begin
            valid_next = '0;
        end else if (ctl.wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end else if (ctl.clr_one) begin
            valid_next[wr_addr] = 1'b0;
        end
        rd_valid_next = rd_valid_reg;
        if (ctl.rd_en) begin
            rd_valid_next = valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_value = rd_valid_reg ? rd_data_reg : 32'd0;

endmodule

// ===== design/stff_scan.sv =====
module stff_scan #(
    parameter int SLOTS = 16,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  stff_pkg::in_item_t in_item,
    input  logic               out_free,
    output logic               out_load,
    output stff_pkg::out_item_t out_item,
    output stff_pkg::mem_ctl_t mem_ctl,
    output logic [IW-1:0]      rd_addr,
    output logic [IW-1:0]      wr_addr,
    output logic [31:0]        wr_data,
    input  logic [31:0]        rd_value
);

    localparam logic [IW:0]   SLOTS_W = (IW + 1)'(SLOTS);
    localparam logic [IW-1:0] LAST    = IW'(SLOTS - 1);

    stff_pkg::scan_state_t state_reg, state_next;
    stff_pkg::mode_t       mode_reg, mode_next;
    logic [31:0]           token_reg, token_next;
    logic [IW:0]           issue_reg, issue_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IW-1:0]         chk_idx_reg, chk_idx_next;
    logic [CW-1:0]         count_reg, count_next;
    stff_pkg::status_t     res_status_reg, res_status_next;
    logic [7:0]            res_index_reg, res_index_next;
    logic [31:0]           res_value_reg, res_value_next;

    logic accept;
    logic in_null;
    logic get_in_range;
    logic match;
    logic scan_last;
    logic [31:0] target;

    assign accept       = in_valid && in_ready;
    assign in_null      = (in_item.item_value == 32'd0);
    assign get_in_range = (9'(in_item.slot_index) < 9'(SLOTS));
    assign target       = (mode_reg == stff_pkg::MODE_ADD) ? 32'd0 : token_reg;
    assign match        = chk_valid_reg && (rd_value == target);
    assign scan_last    = chk_valid_reg && (chk_idx_reg == LAST);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stff_pkg::SCN_IDLE: begin
                if (accept) begin
                    if (in_item.mode == stff_pkg::MODE_CLEAR) begin
                        state_next = stff_pkg::SCN_DONE;
                    end else if (in_item.mode == stff_pkg::MODE_GET) begin
                        state_next = get_in_range ? stff_pkg::SCN_GET : stff_pkg::SCN_DONE;
                    end else begin
                        state_next = in_null ? stff_pkg::SCN_DONE : stff_pkg::SCN_SCAN;
                    end
                end
            end
            stff_pkg::SCN_GET: begin
                state_next = stff_pkg::SCN_DONE;
            end
            stff_pkg::SCN_SCAN: begin
                if (match || scan_last) begin
                    state_next = stff_pkg::SCN_DONE;
                end
            end
            stff_pkg::SCN_DONE: begin
                if (out_free) begin
                    state_next = stff_pkg::SCN_IDLE;
                end
            end
            default: begin
                state_next = stff_pkg::SCN_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready        = 1'b0;
        out_load        = 1'b0;
        mem_ctl         = '0;
        rd_addr         = issue_reg[IW-1:0];
        wr_addr         = chk_idx_reg;
        wr_data         = token_reg;
        mode_next       = mode_reg;
        token_next      = token_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_value_next  = res_value_reg;
        case (state_reg)
            stff_pkg::SCN_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    mode_next       = in_item.mode;
                    token_next      = in_item.item_value;
                    issue_next      = '0;
                    res_status_next = stff_pkg::ST_OK;
                    res_index_next  = 8'd0;
                    res_value_next  = 32'd0;
                    if (in_item.mode == stff_pkg::MODE_CLEAR) begin
                        mem_ctl.clr_all = 1'b1;
                        count_next      = '0;
                    end else if (in_item.mode == stff_pkg::MODE_GET) begin
                        rd_addr = in_item.slot_index[IW-1:0];
                        if (get_in_range) begin
                            mem_ctl.rd_en = 1'b1;
                        end else begin
                            res_status_next = stff_pkg::ST_MISS;
                        end
                    end else if (in_null) begin
                        res_status_next = stff_pkg::ST_NULL;
                    end
                end
            end
            stff_pkg::SCN_GET: begin
                res_value_next = rd_value;
                if (rd_value == 32'd0) begin
                    res_status_next = stff_pkg::ST_MISS;
                end
            end
            stff_pkg::SCN_SCAN: begin
                // Reads are issued one per cycle; the entry read last cycle
                // is compared while the next one is fetched.
                if (match) begin
                    res_index_next = 8'(chk_idx_reg);
                    if (mode_reg == stff_pkg::MODE_ADD) begin
                        mem_ctl.wr_en = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end else begin
                        mem_ctl.clr_one = 1'b1;
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end else if (scan_last) begin
                    res_status_next = (mode_reg == stff_pkg::MODE_ADD) ? stff_pkg::ST_FULL
                                                                       : stff_pkg::ST_MISS;
                end else if (issue_reg < SLOTS_W) begin
                    mem_ctl.rd_en  = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[IW-1:0];
                end
            end
            stff_pkg::SCN_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= stff_pkg::SCN_IDLE;
            chk_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        token_reg      <= token_next;
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_value_reg  <= res_value_next;
    end

    always_comb begin
        out_item.status       = res_status_reg;
        out_item.result_index = res_index_reg;
        out_item.result_value = res_value_reg;
        out_item.stored_count = 9'(count_reg);
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(SLOTS))
        else $error("occupied count exceeds the table size");

    a_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctl.wr_en || mem_ctl.clr_one) |-> (state_reg == stff_pkg::SCN_SCAN && match))
        else $error("slot written outside a matching scan step");

    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_item.mode == stff_pkg::MODE_CLEAR) |=> (count_reg == '0))
        else $error("count not zero after clear");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == stff_pkg::SCN_IDLE && !chk_valid_reg))
        else $error("sequencer did not return to idle after a result");
`endif

endmodule
